// ===== rtl/itp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_pkg: shared definitions for the infix to postfix converter
// Token codes, result codes, opcode precedence and controller/datapath structs.
// ----------------------------------------------------------------------------
package itp_pkg;

    localparam int TOK_W          = 16;
    localparam int KIND_W         = 3;
    localparam int ERR_W          = 3;
    localparam int OPC_W          = 3;
    localparam int DEF_OP_DEPTH   = 16;
    localparam int DEF_FUNC_DEPTH = 16;
    localparam int DEF_ID_BITS    = 16;

    // Input token kinds.
    localparam logic [KIND_W-1:0] KIND_OPERAND     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_OPERATOR    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_OPEN_PAREN  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_CLOSE_PAREN = 3'd3;
    localparam logic [KIND_W-1:0] KIND_OPEN_BRKT   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_CLOSE_BRKT  = 3'd5;
    localparam logic [KIND_W-1:0] KIND_COMMA       = 3'd6;
    localparam logic [KIND_W-1:0] KIND_END         = 3'd7;

    // Result kinds.
    localparam logic [KIND_W-1:0] OK_OPERAND  = 3'd0;
    localparam logic [KIND_W-1:0] OK_OPERATOR = 3'd1;
    localparam logic [KIND_W-1:0] OK_FUNC     = 3'd2;
    localparam logic [KIND_W-1:0] OK_DONE     = 3'd3;
    localparam logic [KIND_W-1:0] OK_ERROR    = 3'd4;

    // Error codes.
    localparam logic [ERR_W-1:0] ERR_NONE     = 3'd0;
    localparam logic [ERR_W-1:0] ERR_PAREN    = 3'd1;
    localparam logic [ERR_W-1:0] ERR_BRACKET  = 3'd2;
    localparam logic [ERR_W-1:0] ERR_NOFUNC   = 3'd3;
    localparam logic [ERR_W-1:0] ERR_OVERFLOW = 3'd4;

    // Operator stack entry codes.
    localparam logic [OPC_W-1:0] OPC_PLUS    = 3'd0;
    localparam logic [OPC_W-1:0] OPC_MINUS   = 3'd1;
    localparam logic [OPC_W-1:0] OPC_TIMES   = 3'd2;
    localparam logic [OPC_W-1:0] OPC_DIVIDE  = 3'd3;
    localparam logic [OPC_W-1:0] OPC_POWER   = 3'd4;
    localparam logic [OPC_W-1:0] OPC_PAREN   = 3'd5;
    localparam logic [OPC_W-1:0] OPC_BRACKET = 3'd6;

    typedef enum logic [2:0] {
        SRC_OPERAND,
        SRC_OP_TOP,
        SRC_FUNC_TOP,
        SRC_ERROR,
        SRC_DONE
    } t_src;

    typedef struct packed {
        logic             load;
        logic             emit;
        t_src             src;
        logic [ERR_W-1:0] err_code;
        logic             set_err;
        logic             push_op;
        logic             pop_op;
        logic             push_func;
        logic             pop_func;
        logic             clear;
        logic             finish;
    } t_cmd;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              nb;
        logic              tok_ok;
        logic              err_seen;
        logic              op_empty;
        logic              op_full;
        logic              top_paren;
        logic              top_bracket;
        logic              prec_ge;
        logic              func_empty;
        logic              func_full;
        logic              emit_ok;
    } t_stat;

    // Precedence: power highest, then times/divide, then plus/minus; openers lowest.
    function automatic logic [1:0] prec(input logic [OPC_W-1:0] code);
        logic [1:0] p;
        case (code)
            OPC_POWER:              p = 2'd3;
            OPC_TIMES, OPC_DIVIDE:  p = 2'd2;
            OPC_PLUS, OPC_MINUS:    p = 2'd1;
            default:                p = 2'd0;
        endcase
        return p;
    endfunction

endpackage

// ===== rtl/infix_to_postfix_converter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_top: shunting-yard token converter
// Turns a stream of classified infix tokens into postfix order with function
// names, a done marker per expression and error results.
// ----------------------------------------------------------------------------
// Usage:
//   Tokens arrive on the slave stream, one request per token. The kind code
//   and the function-name lookahead flag travel in tuser, the identifier or
//   operator code in tdata. Results leave on the master stream: the result
//   kind in tuser, token and error code in tdata, and tlast marks the final
//   result caused by one input token.
//   A token is taken only while the sequencer is idle. It then passes through
//   dispatch, stack steps at one per cycle while the output has room (each
//   pop, push or emit walks one stack entry), a check that sees a pop loop
//   has ended, and a closing step. The stacks' registered top-of-stack read
//   is what limits the walk to one entry a cycle.
//   Each result is staged once so that tlast can be known, and moves to the
//   output when the next result is staged or the token closes.
//   When the receiver stalls, one result waits in the output register and
//   one in the staging register; further steps hold until space frees up,
//   and no result is lost or repeated. Output data holds while stalled.
//   Synchronous reset empties both stacks, clears the error flag and drops
//   any staged results. An end token empties both stacks and clears the error flag as its done marker is staged.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_top import itp_pkg::*; #(
    parameter int OP_DEPTH   = DEF_OP_DEPTH,
    parameter int FUNC_DEPTH = DEF_FUNC_DEPTH,
    parameter int ID_BITS    = DEF_ID_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Slave stream: input tokens.
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    input  logic [TOK_W-1:0]    i_s_axis_tdata,   // [15:0] token_id
    input  logic [KIND_W:0]     i_s_axis_tuser,   // [2:0] kind, [3] next_is_bracket
    // Master stream: postfix results.
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    output logic [23:0]         o_m_axis_tdata,   // [15:0] out_token, [18:16] error_code,
                                                  // [23:19] zero
    output logic [KIND_W-1:0]   o_m_axis_tuser,   // [2:0] out_kind
    output logic                o_m_axis_tlast    // last_of_run
);

    t_cmd              w_cmd;
    t_stat             w_stat;
    logic [TOK_W-1:0]  w_out_tok;
    logic [ERR_W-1:0]  w_out_err;

    // The sequencer decides each step; the datapath owns all storage.
    itp_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    itp_datapath #(
        .OP_DEPTH   (OP_DEPTH),
        .FUNC_DEPTH (FUNC_DEPTH),
        .ID_BITS    (ID_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok       (i_s_axis_tdata),
        .i_kind      (i_s_axis_tuser[KIND_W-1:0]),
        .i_nb        (i_s_axis_tuser[KIND_W]),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_kind  (o_m_axis_tuser),
        .o_out_tok   (w_out_tok),
        .o_out_err   (w_out_err),
        .o_out_last  (o_m_axis_tlast)
    );

    // Pack the result fields from the lowest bit up, zero filled to 3 bytes.
    assign o_m_axis_tdata = {5'b0, w_out_err, w_out_tok};

    // A token is taken only from idle, so the next cycle cannot take another.
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("second token accepted while the first is still in work");

    // No stack step or run close happens while the sequencer waits for a token.
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> (!w_cmd.emit && !w_cmd.finish && !w_cmd.pop_op &&
                             !w_cmd.push_op))
        else $error("datapath command issued while idle");

    // The done marker is always the final result of its end token.
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser == OK_DONE) |-> o_m_axis_tlast)
        else $error("done marker without end of run");

    // An error result carries its code both as token and as error code.
    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser == OK_ERROR) |->
            (o_m_axis_tdata[18:16] != ERR_NONE &&
             o_m_axis_tdata[15:0] == TOK_W'(o_m_axis_tdata[18:16])))
        else $error("error result with inconsistent code");

endmodule

// ===== rtl/itp_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_datapath: stacks, token register and result staging
// Holds the operator and function stacks with registered top-of-stack reads,
// a one-deep pending result that decides the end-of-run flag, and the output
// register of the master channel.
// ----------------------------------------------------------------------------
module itp_datapath import itp_pkg::*; #(
    parameter int OP_DEPTH   = DEF_OP_DEPTH,
    parameter int FUNC_DEPTH = DEF_FUNC_DEPTH,
    parameter int ID_BITS    = DEF_ID_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [TOK_W-1:0]  i_tok,
    input  logic [KIND_W-1:0] i_kind,
    input  logic              i_nb,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [KIND_W-1:0] o_out_kind,
    output logic [TOK_W-1:0]  o_out_tok,
    output logic [ERR_W-1:0]  o_out_err,
    output logic              o_out_last
);

    localparam int FW      = (ID_BITS < TOK_W) ? ID_BITS : TOK_W;
    localparam int OP_CW   = $clog2(OP_DEPTH + 1);
    localparam int OP_AW   = $clog2(OP_DEPTH);
    localparam int FUNC_CW = $clog2(FUNC_DEPTH + 1);
    localparam int FUNC_AW = (FUNC_DEPTH > 1) ? $clog2(FUNC_DEPTH) : 1;

    logic [TOK_W-1:0]   r_tok;
    logic [KIND_W-1:0]  r_kind;
    logic               r_nb;
    logic               r_err;

    logic [OPC_W-1:0]   r_op_mem [OP_DEPTH];
    logic [OP_CW-1:0]   r_op_cnt, n_op_cnt;
    logic [OPC_W-1:0]   r_op_top;
    logic [OP_AW-1:0]   w_op_rd_addr;
    logic [OPC_W-1:0]   w_push_code;

    logic [FW-1:0]      r_func_mem [FUNC_DEPTH];
    logic [FUNC_CW-1:0] r_func_cnt, n_func_cnt;
    logic [FW-1:0]      r_func_top;
    logic [FUNC_AW-1:0] w_func_rd_addr;

    logic               r_pnd_valid;
    logic [KIND_W-1:0]  r_pnd_kind;
    logic [TOK_W-1:0]   r_pnd_tok;
    logic [ERR_W-1:0]   r_pnd_err;
    logic [KIND_W-1:0]  w_em_kind;
    logic [TOK_W-1:0]   w_em_tok;
    logic [ERR_W-1:0]   w_em_err;
    logic               w_move;

    logic               r_out_valid;
    logic [KIND_W-1:0]  r_out_kind;
    logic [TOK_W-1:0]   r_out_tok;
    logic [ERR_W-1:0]   r_out_err;
    logic               r_out_last;

    always_comb begin
        if (r_kind == KIND_OPEN_PAREN) begin
            w_push_code = OPC_PAREN;
        end else if (r_kind == KIND_OPEN_BRKT) begin
            w_push_code = OPC_BRACKET;
        end else begin
            w_push_code = r_tok[OPC_W-1:0];
        end
    end

    always_comb begin
        n_op_cnt = r_op_cnt;
        if (i_cmd.clear) begin
            n_op_cnt = '0;
        end else if (i_cmd.push_op) begin
            n_op_cnt = r_op_cnt + OP_CW'(1);
        end else if (i_cmd.pop_op) begin
            n_op_cnt = r_op_cnt - OP_CW'(1);
        end
        n_func_cnt = r_func_cnt;
        if (i_cmd.clear) begin
            n_func_cnt = '0;
        end else if (i_cmd.push_func) begin
            n_func_cnt = r_func_cnt + FUNC_CW'(1);
        end else if (i_cmd.pop_func) begin
            n_func_cnt = r_func_cnt - FUNC_CW'(1);
        end
    end

    assign w_op_rd_addr   = OP_AW'(n_op_cnt - OP_CW'(1));
    assign w_func_rd_addr = FUNC_AW'(n_func_cnt - FUNC_CW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op_cnt   <= '0;
            r_func_cnt <= '0;
            r_err      <= 1'b0;
        end else begin
            r_op_cnt   <= n_op_cnt;
            r_func_cnt <= n_func_cnt;
            if (i_cmd.clear) begin
                r_err <= 1'b0;
            end else if (i_cmd.set_err) begin
                r_err <= 1'b1;
            end
        end
    end

    // The top register always tracks the entry below the next count.
    always_ff @(posedge i_clk) begin
        if (i_cmd.push_op) begin
            r_op_mem[r_op_cnt[OP_AW-1:0]] <= w_push_code;
            r_op_top <= w_push_code;
        end else if (n_op_cnt != '0) begin
            r_op_top <= r_op_mem[w_op_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push_func) begin
            r_func_mem[FUNC_AW'(r_func_cnt)] <= r_tok[FW-1:0];
            r_func_top <= r_tok[FW-1:0];
        end else if (n_func_cnt != '0) begin
            r_func_top <= r_func_mem[w_func_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_tok  <= i_tok;
            r_kind <= i_kind;
            r_nb   <= i_nb;
        end
    end

    always_comb begin
        w_em_err = ERR_NONE;
        case (i_cmd.src)
            SRC_OPERAND: begin
                w_em_kind = OK_OPERAND;
                w_em_tok  = TOK_W'(r_tok[FW-1:0]);
            end
            SRC_OP_TOP: begin
                w_em_kind = OK_OPERATOR;
                w_em_tok  = TOK_W'(r_op_top);
            end
            SRC_FUNC_TOP: begin
                w_em_kind = OK_FUNC;
                w_em_tok  = TOK_W'(r_func_top);
            end
            SRC_ERROR: begin
                w_em_kind = OK_ERROR;
                w_em_tok  = TOK_W'(i_cmd.err_code);
                w_em_err  = i_cmd.err_code;
            end
            default: begin
                w_em_kind = OK_DONE;
                w_em_tok  = '0;
            end
        endcase
    end

    // A pending result moves out when a newer one arrives or the token ends.
    assign w_move = r_pnd_valid && (i_cmd.emit || i_cmd.finish);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pnd_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.emit) begin
                r_pnd_valid <= 1'b1;
            end else if (i_cmd.finish) begin
                r_pnd_valid <= 1'b0;
            end
            if (w_move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_pnd_kind <= w_em_kind;
            r_pnd_tok  <= w_em_tok;
            r_pnd_err  <= w_em_err;
        end
        if (w_move) begin
            r_out_kind <= r_pnd_kind;
            r_out_tok  <= r_pnd_tok;
            r_out_err  <= r_pnd_err;
            r_out_last <= i_cmd.finish;
        end
    end

    always_comb begin
        o_stat.kind        = r_kind;
        o_stat.nb          = r_nb;
        o_stat.tok_ok      = (r_tok <= TOK_W'(OPC_POWER));
        o_stat.err_seen    = r_err;
        o_stat.op_empty    = (r_op_cnt == '0);
        o_stat.op_full     = (r_op_cnt == OP_CW'(OP_DEPTH));
        o_stat.top_paren   = (r_op_top == OPC_PAREN);
        o_stat.top_bracket = (r_op_top == OPC_BRACKET);
        o_stat.prec_ge     = (prec(r_op_top) >= prec(r_tok[OPC_W-1:0]));
        o_stat.func_empty  = (r_func_cnt == '0);
        o_stat.func_full   = (r_func_cnt == FUNC_CW'(FUNC_DEPTH));
        o_stat.emit_ok     = !r_pnd_valid || !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_kind  = r_out_kind;
    assign o_out_tok   = r_out_tok;
    assign o_out_err   = r_out_err;
    assign o_out_last  = r_out_last;

endmodule

// ===== rtl/itp_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_controller: token sequencer
// Walks each token through its push, pop and emit steps, one stack step per
// cycle while the output has room, and closes each token's run of results.
// ----------------------------------------------------------------------------
module itp_controller import itp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_OPER_POP,
        S_PUSH,
        S_POP_TO,
        S_FUNC_EMIT,
        S_FLUSH_F,
        S_FLUSH_O,
        S_DONE,
        S_FINISH
    } t_state;

    t_state r_state, n_state;
    logic   w_want_paren;
    logic   w_top_opener;

    assign w_want_paren = (i_stat.kind == KIND_CLOSE_PAREN);
    assign w_top_opener = i_stat.top_paren || i_stat.top_bracket;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.src = SRC_DONE;
        o_cmd.err_code = ERR_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_stat.kind == KIND_END) begin
                    n_state = i_stat.err_seen ? S_DONE : S_FLUSH_F;
                end else if (i_stat.err_seen) begin
                    n_state = S_FINISH;
                end else begin
                    case (i_stat.kind)
                        KIND_OPERAND: begin
                            if (i_stat.nb && i_stat.func_full) begin
                                if (i_stat.emit_ok) begin
                                    o_cmd.emit     = 1'b1;
                                    o_cmd.src      = SRC_ERROR;
                                    o_cmd.err_code = ERR_OVERFLOW;
                                    o_cmd.set_err  = 1'b1;
                                    n_state        = S_FINISH;
                                end
                            end else if (i_stat.nb) begin
                                o_cmd.push_func = 1'b1;
                                n_state         = S_FINISH;
                            end else if (i_stat.emit_ok) begin
                                o_cmd.emit = 1'b1;
                                o_cmd.src  = SRC_OPERAND;
                                n_state    = S_FINISH;
                            end
                        end
                        KIND_OPERATOR: begin
                            n_state = i_stat.tok_ok ? S_OPER_POP : S_FINISH;
                        end
                        KIND_OPEN_PAREN, KIND_OPEN_BRKT: begin
                            n_state = S_PUSH;
                        end
                        default: begin
                            n_state = S_POP_TO;
                        end
                    endcase
                end
            end
            S_OPER_POP: begin
                if (i_stat.op_empty || !i_stat.prec_ge) begin
                    n_state = S_PUSH;
                end else if (i_stat.emit_ok) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.src    = SRC_OP_TOP;
                    o_cmd.pop_op = 1'b1;
                end
            end
            S_PUSH: begin
                if (!i_stat.op_full) begin
                    o_cmd.push_op = 1'b1;
                    n_state       = S_FINISH;
                end else if (i_stat.emit_ok) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.src      = SRC_ERROR;
                    o_cmd.err_code = ERR_OVERFLOW;
                    o_cmd.set_err  = 1'b1;
                    n_state        = S_FINISH;
                end
            end
            S_POP_TO: begin
                if (!i_stat.op_empty && w_want_paren && i_stat.top_paren) begin
                    o_cmd.pop_op = 1'b1;
                    n_state      = S_FINISH;
                end else if (!i_stat.op_empty && !w_want_paren && i_stat.top_bracket) begin
                    if (i_stat.kind == KIND_CLOSE_BRKT) begin
                        o_cmd.pop_op = 1'b1;
                        n_state      = S_FUNC_EMIT;
                    end else begin
                        n_state = S_FINISH;
                    end
                end else if (i_stat.emit_ok) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.op_empty || w_top_opener) begin
                        o_cmd.src      = SRC_ERROR;
                        o_cmd.err_code = w_want_paren ? ERR_PAREN : ERR_BRACKET;
                        o_cmd.set_err  = 1'b1;
                        n_state        = S_FINISH;
                    end else begin
                        o_cmd.src    = SRC_OP_TOP;
                        o_cmd.pop_op = 1'b1;
                    end
                end
            end
            S_FUNC_EMIT: begin
                if (i_stat.emit_ok) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_FINISH;
                    if (i_stat.func_empty) begin
                        o_cmd.src      = SRC_ERROR;
                        o_cmd.err_code = ERR_NOFUNC;
                        o_cmd.set_err  = 1'b1;
                    end else begin
                        o_cmd.src      = SRC_FUNC_TOP;
                        o_cmd.pop_func = 1'b1;
                    end
                end
            end
            S_FLUSH_F: begin
                if (i_stat.func_empty) begin
                    n_state = S_FLUSH_O;
                end else if (i_stat.emit_ok) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.src      = SRC_FUNC_TOP;
                    o_cmd.pop_func = 1'b1;
                end
            end
            S_FLUSH_O: begin
                if (i_stat.op_empty) begin
                    n_state = S_DONE;
                end else if (i_stat.emit_ok) begin
                    o_cmd.emit = 1'b1;
                    if (w_top_opener) begin
                        o_cmd.src      = SRC_ERROR;
                        o_cmd.err_code = i_stat.top_paren ? ERR_PAREN : ERR_BRACKET;
                        o_cmd.set_err  = 1'b1;
                        n_state        = S_DONE;
                    end else begin
                        o_cmd.src    = SRC_OP_TOP;
                        o_cmd.pop_op = 1'b1;
                    end
                end
            end
            S_DONE: begin
                if (i_stat.emit_ok) begin
                    o_cmd.emit  = 1'b1;
                    o_cmd.src   = SRC_DONE;
                    o_cmd.clear = 1'b1;
                    n_state     = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_stat.emit_ok) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule
